// ----- rtl/mvf_pkg.sv -----
// ============================================================================
// mvf_pkg : shared types and constants for the modal value finder
// Holds the default store depth, result count width and state encoding.
// ============================================================================
`default_nettype none

package mvf_pkg;

    // Default depth of the entry store
    localparam int unsigned MAX_ENTRIES_DEF = 256;

    // Width of the result count field
    localparam int unsigned MODE_COUNT_W = 9;

    // Controller states
    typedef enum logic [2:0] {
        ST_LOAD,   // accept entries into the store
        ST_CAND,   // address the next candidate
        ST_CWAIT,  // latch the candidate, start its scan
        ST_SCAN,   // compare every stored entry against the candidate
        ST_DONE    // hand the result to the output register
    } mvf_state_t;

endpackage : mvf_pkg

`default_nettype wire

// ----- rtl/modal_value_finder_top.sv -----
// ============================================================================
// modal_value_finder_top : mode of a run of signed 32-bit values
//
// Input channel (s_*): one word per entry, carrying present, entry_value and
// last_entry. Entries are written into a single-port-read store, an absent
// entry as zero. Entries past MAX_ENTRIES are dropped, but a dropped closing
// word still closes the run.
// Result channel (m_*): one word per run: found, mode_value, mode_count.
// mode_count saturates at 511.
// Loading takes one word per cycle, in the load state only. After the
// closing word the block walks the store: each candidate is fetched in
// the CAND and CWAIT states, and each non-zero candidate then scans all
// n stored entries through the registered read port. Input is not
// accepted during the scan.
// The result sits in an output register; the next run may load while it
// waits. If the receiver still stalls when the next scan ends, the block
// holds in its final state until the word is taken.
// Reset clears the fill count, the controller and the output valid; the
// store needs no clearing since only written entries are ever read.
// ============================================================================
`default_nettype none

module modal_value_finder_top
    import mvf_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // entry words
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire                            s_present,
    input  wire signed [31:0]              s_entry_value,
    input  wire                            s_last_entry,
    // result words
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic                           m_found,
    output logic signed [31:0]             m_mode_value,
    output logic [MODE_COUNT_W-1:0]        m_mode_count
);

    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    // Entry store
    logic [31:0]        mem [MAX_ENTRIES];
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data_reg;

    // Control and datapath registers
    mvf_state_t         state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [31:0]        cand_reg, cand_next;
    logic [31:0]        best_val_reg, best_val_next;
    logic [CW-1:0]      best_cnt_reg, best_cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_value_reg, m_value_next;
    logic [CW-1:0]      m_count_reg, m_count_next;

    logic               last_cand;
    logic               match;
    logic [CW-1:0]      cnt_sum;
    logic               accept;

    // Store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign accept    = s_valid && s_ready;
    assign last_cand = (CW'(i_reg) == (n_reg - CW'(1)));
    assign match     = (rd_data_reg == cand_reg);
    assign cnt_sum   = cnt_reg + CW'(match);

    // Next state and datapath
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cnt_next      = cnt_reg;
        cand_next     = cand_reg;
        best_val_next = best_val_reg;
        best_cnt_next = best_cnt_reg;
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_count_next  = m_count_reg;
        s_ready       = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[AW-1:0];
        wr_data       = s_present ? s_entry_value : 32'd0;
        rd_addr       = i_reg;

        // drop the result word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (fill_reg < CW'(MAX_ENTRIES)) begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                    if (s_last_entry) begin
                        n_next        = fill_next;
                        fill_next     = '0;
                        i_next        = '0;
                        best_val_next = '0;
                        best_cnt_next = '0;
                        state_next    = (n_next == '0) ? ST_DONE : ST_CAND;
                    end
                end
            end
            ST_CAND: begin
                rd_addr    = i_reg;
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (rd_data_reg == 32'd0) begin
                    // zero is never a candidate: advance
                    if (last_cand) begin
                        state_next = ST_DONE;
                    end else begin
                        i_next     = i_reg + AW'(1);
                        state_next = ST_CAND;
                    end
                end else begin
                    cand_next  = rd_data_reg;
                    cnt_next   = '0;
                    rd_addr    = '0;
                    j_next     = CW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (j_reg == n_reg) begin
                    // scan complete: keep only a strictly larger count
                    if (cnt_sum > best_cnt_reg) begin
                        best_val_next = cand_reg;
                        best_cnt_next = cnt_sum;
                    end
                    if (last_cand) begin
                        state_next = ST_DONE;
                    end else begin
                        i_next     = i_reg + AW'(1);
                        state_next = ST_CAND;
                    end
                end else begin
                    rd_addr  = j_reg[AW-1:0];
                    j_next   = j_reg + CW'(1);
                    cnt_next = cnt_sum;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = best_val_reg;
                    m_count_next = best_cnt_reg;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
            best_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_valid_reg  <= m_valid_next;
            best_cnt_reg <= best_cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        cand_reg     <= cand_next;
        best_val_reg <= best_val_next;
        m_value_reg  <= m_value_next;
        m_count_reg  <= m_count_next;
    end

    // Result outputs, count saturated to the field width
    assign m_valid      = m_valid_reg;
    assign m_found      = (m_count_reg != '0);
    assign m_mode_value = m_value_reg;

    generate
        if (CW > MODE_COUNT_W) begin : g_sat
            assign m_mode_count = (m_count_reg > CW'({MODE_COUNT_W{1'b1}}))
                                ? {MODE_COUNT_W{1'b1}}
                                : m_count_reg[MODE_COUNT_W-1:0];
        end else begin : g_nosat
            assign m_mode_count = MODE_COUNT_W'(m_count_reg);
        end
    endgenerate

endmodule : modal_value_finder_top

`default_nettype wire

// ----- bench/tb_top.sv -----
// ============================================================================
// tb_top : self-checking bench for modal_value_finder_top
//
// Feeds runs of entry words through the valid/ready input channel and checks
// each result word against a mode calculated in the bench. A directed table
// comes first: absent and zero entries, the signed extremes, ties and
// repeated values. Random runs follow, mostly drawn from a small set of
// values so that repeats and ties are common. Three full-length runs also
// fill the store: one exactly full of a single repeated value for the
// largest count, and two overflowing with the closing word dropped. Both
// channels idle and stall at random.
// ============================================================================
`default_nettype none

module tb_top
    import mvf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The limit allows for three full-store scans plus the short runs with
    // their gaps, scans and stalls, so this is ample.
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned ENTRY_TARGET = 1850;
    localparam int unsigned LONG_RUNS = 3;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic                    found;
        logic [31:0]             value;
        logic [MODE_COUNT_W-1:0] count;
    } mode_result_t;

    typedef struct packed {
        logic         present;
        logic [31:0]  value;
        logic         last;
        logic         typed;
        mode_result_t want;
    } entry_row_t;

    localparam int unsigned DIRECTED_ROWS = 24;

    // Typed results only where they can be read off directly
    localparam entry_row_t DIRECTED [DIRECTED_ROWS] = '{
        // lone absent entry: no candidate
        '{1'b0, 32'h1234_5678, 1'b1, 1'b1, '{1'b0, 32'h0, 9'd0}},
        // lone zero: zero is never a candidate
        '{1'b1, 32'h0000_0000, 1'b1, 1'b1, '{1'b0, 32'h0, 9'd0}},
        // signed extremes and all-ones
        '{1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1, '{1'b1, 32'h7FFF_FFFF, 9'd1}},
        '{1'b1, 32'h8000_0000, 1'b1, 1'b1, '{1'b1, 32'h8000_0000, 9'd1}},
        '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b1, 32'hFFFF_FFFF, 9'd1}},
        // absent copy of a value is not counted
        '{1'b1, 32'd5,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b0, 32'd5,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'd5,         1'b1, 1'b1, '{1'b1, 32'd5, 9'd2}},
        // tie in count: earliest first occurrence wins
        '{1'b1, 32'd7,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'd3,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'd3,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'd7,         1'b1, 1'b1, '{1'b1, 32'd7, 9'd2}},
        // later candidate overtakes
        '{1'b1, 32'd1,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'd2,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'd2,         1'b1, 1'b0, '{1'b0, 32'h0, 9'd0}},
        // leading zeros are skipped
        '{1'b1, 32'h0,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'h0,         1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'hFFFF_FFF7, 1'b1, 1'b1, '{1'b1, 32'hFFFF_FFF7, 9'd1}},
        // absent entries around a repeated minimum
        '{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'h8000_0000, 1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'h8000_0000, 1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b0, 32'h8000_0000, 1'b1, 1'b0, '{1'b0, 32'h0, 9'd0}},
        // alternating bit patterns
        '{1'b1, 32'h5555_5555, 1'b0, 1'b0, '{1'b0, 32'h0, 9'd0}},
        '{1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0, '{1'b0, 32'h0, 9'd0}}
    };

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_present = 1'b0;
    logic signed [31:0]      s_entry_value = '0;
    logic                    s_last_entry = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_found;
    logic signed [31:0]      m_mode_value;
    logic [MODE_COUNT_W-1:0] m_mode_count;

    // Predictor state: entries of the open run, and modes still owed
    logic [31:0]  run_values [$];
    mode_result_t pending_modes [$];
    mode_result_t seen_mode;

    int unsigned mode_errors = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned entries_sent = 0;
    int unsigned long_runs_done = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned pattern_age = 0;

    modal_value_finder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_present     (s_present),
        .s_entry_value (s_entry_value),
        .s_last_entry  (s_last_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_mode_value  (m_mode_value),
        .m_mode_count  (m_mode_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Most frequent non-zero value of the open run, earliest on ties
    function automatic mode_result_t tally_mode();
        mode_result_t best;
        int unsigned  best_hits;
        int unsigned  hits;
        best = '0;
        best_hits = 0;
        foreach (run_values[i]) begin
            if (run_values[i] != 32'd0) begin
                hits = 0;
                foreach (run_values[j]) begin
                    if (run_values[j] == run_values[i]) hits++;
                end
                if (hits > best_hits) begin
                    best_hits = hits;
                    best.found = 1'b1;
                    best.value = run_values[i];
                    best.count = (hits > 511) ? 9'd511 : hits[MODE_COUNT_W-1:0];
                end
            end
        end
        return best;
    endfunction

    // Store an accepted word; on the closing word owe one mode word
    task automatic absorb_entry(input logic present, input logic [31:0] value,
                                input logic last, input logic typed,
                                input mode_result_t want);
        mode_result_t owed;
        if (run_values.size() < MAX_ENTRIES_DEF)
            run_values.push_back(present ? value : 32'd0);
        if (last) begin
            owed = tally_mode();
            pending_modes.push_back(typed ? want : owed);
            run_values.delete();
        end
    endtask

    // Drive one word, idling between bursts; valid stays high across a burst
    task automatic send_entry(input logic present, input logic [31:0] value,
                              input logic last, input logic typed,
                              input mode_result_t want);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_valid       <= 1'b1;
        s_present     <= present;
        s_entry_value <= value;
        s_last_entry  <= last;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        entries_sent++;
        absorb_entry(present, value, last, typed, want);
    endtask

    function automatic logic [31:0] pick_value(input bit allow_zero);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'hFFFF_FFFF;
            3:       v = allow_zero ? 32'h0 : 32'h1;
            4, 5:    v = $urandom_range(0, 15) - 8;
            default: v = $urandom;
        endcase
        if (!allow_zero && v == 32'h0) v = 32'h1;
        return v;
    endfunction

    // One run: noisy runs use raw random words, others a small value set
    task automatic send_run(input int unsigned run_len, input bit noisy,
                            input int unsigned alpha_max, input int unsigned absent_pct);
        logic [31:0] alphabet [6];
        int unsigned alpha_n;
        logic        present;
        logic [31:0] value;
        alpha_n = $urandom_range(1, alpha_max);
        foreach (alphabet[k]) alphabet[k] = pick_value(alpha_max > 1);
        for (int unsigned i = 0; i < run_len; i++) begin
            if (noisy) begin
                present = 1'($urandom_range(0, 1));
                value   = $urandom;
            end else begin
                present = ($urandom_range(0, 99) >= absent_pct);
                value   = alphabet[$urandom_range(0, alpha_n - 1)];
            end
            send_entry(present, value, i == run_len - 1, 1'b0, '0);
        end
    endtask

    // Receiver: rotate a stall pattern, reloading it now and then
    always @(posedge aclk) begin
        m_ready <= ready_pattern[0];
        if (pattern_age == 96) begin
            pattern_age <= 0;
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'h0001;
                default: ready_pattern <= 16'($urandom) | 16'h0001;
            endcase
        end else begin
            pattern_age   <= pattern_age + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // Compare each result word with the oldest owed mode
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_modes.size() == 0) begin
                mode_errors++;
                if (mode_errors <= MAX_REPORTS)
                    $display("unexpected result word: found=%0d value=%0d count=%0d",
                             m_found, m_mode_value, m_mode_count);
            end else begin
                seen_mode = pending_modes.pop_front();
                if (m_found !== seen_mode.found || m_mode_value !== seen_mode.value
                        || m_mode_count !== seen_mode.count) begin
                    mode_errors++;
                    if (mode_errors <= MAX_REPORTS)
                        $display("mode word wrong: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 seen_mode.found, $signed(seen_mode.value),
                                 seen_mode.count, m_found, m_mode_value, m_mode_count);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modal_value_finder_top: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (DIRECTED[r])
            send_entry(DIRECTED[r].present, DIRECTED[r].value, DIRECTED[r].last,
                       DIRECTED[r].typed, DIRECTED[r].want);

        // Random runs, with full-store runs spread through
        while (entries_sent < ENTRY_TARGET) begin
            if (long_runs_done < LONG_RUNS && entries_sent >= (long_runs_done + 1) * 450) begin
                case (long_runs_done)
                    0:       send_run(MAX_ENTRIES_DEF, 1'b0, 1, 0);
                    1:       send_run(MAX_ENTRIES_DEF + $urandom_range(1, 6), 1'b0, 6, 10);
                    default: send_run(MAX_ENTRIES_DEF + $urandom_range(1, 6), 1'b1, 1, 0);
                endcase
                long_runs_done++;
            end else if ($urandom_range(0, 9) == 0) begin
                send_run($urandom_range(1, 20), 1'b1, 1, 0);
            end else if ($urandom_range(0, 7) == 0) begin
                send_run($urandom_range(13, 48), 1'b0, 6, $urandom_range(0, 30));
            end else begin
                send_run($urandom_range(1, 12), 1'b0, 6, $urandom_range(0, 30));
            end
        end
        s_valid <= 1'b0;

        // Drain owed modes, then allow a short settle
        while (pending_modes.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (mode_errors == 0)
            $display("modal_value_finder_top: match");
        else
            $display("modal_value_finder_top: mismatch");
        $finish;
    end

endmodule : tb_top

`default_nettype wire
